// File: sv/keyed_priority_task_queue_unit_macros.svh
// Assertion macros used by the keyed priority task queue RTL.
`ifndef KEYED_PRIORITY_TASK_QUEUE_UNIT_MACROS_SVH
`define KEYED_PRIORITY_TASK_QUEUE_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define KPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/kpq_pkg.sv
// Types, constants and codes of the keyed priority task queue.
`default_nettype none

package kpq_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OWNER_W = 16;
   localparam int KEY_W   = 16;
   localparam int PRIO_W  = 32;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_WRITE,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      op_type               op;
      logic [OWNER_W-1:0]   owner_id;
      logic [KEY_W-1:0]     task_key;
      logic [PRIO_W-1:0]    prio_value;
   } cmd_type;

   typedef struct packed {
      logic [OWNER_W-1:0]   owner_id;
      logic [KEY_W-1:0]     task_key;
      logic [PRIO_W-1:0]    prio_value;
   } slot_type;

   typedef struct packed {
      status_type           status;
      logic [OWNER_W-1:0]   popped_owner;
   } result_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_W-1:0]    wr_addr;
      slot_type             wr_data;
      logic                 rd_en;
      logic [SLOT_W-1:0]    rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// File: sv/kpq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module kpq_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/kpq_engine.sv
// Scan sequencer: walks the slot RAM, matches keys, tracks the maximum, writes back.
`default_nettype none
`include "keyed_priority_task_queue_unit_macros.svh"

module kpq_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start_i,
   input  wire kpq_pkg::cmd_type     cmd_i,
   input  wire logic                 out_free_i,
   input  wire kpq_pkg::slot_type    rd_data_i,
   output kpq_pkg::mem_req_type      mem_req_o,
   output logic                      idle_o,
   output logic                      done_o,
   output kpq_pkg::result_type       result_o
);

   import kpq_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   eng_state_type       state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic                hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [OWNER_W-1:0]  hit_owner_ff, hit_owner_in;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic                best_found_ff, best_found_in;
   logic [SLOT_W-1:0]   best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic [KEY_W-1:0]    best_key_ff, best_key_in;
   logic [OWNER_W-1:0]  best_owner_ff, best_owner_in;
   result_type          result_ff, result_in;
   logic                entry_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ENG_IDLE;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_owner_ff  <= hit_owner_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_key_ff   <= best_key_in;
      best_owner_ff <= best_owner_in;
      result_ff     <= result_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      valid_in      = valid_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_owner_in  = hit_owner_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_key_in   = best_key_ff;
      best_owner_in = best_owner_ff;
      result_in     = result_ff;
      mem_req_o     = '0;
      done_o        = 1'b0;
      entry_valid   = valid_ff[rd_idx_ff];

      case (state_ff)
         ENG_IDLE: begin
            if (start_i) begin
               cmd_in        = cmd_i;
               addr_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               state_in      = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (addr_ff < CNT_W'(CAPACITY)) begin
               mem_req_o.rd_en   = 1'b1;
               mem_req_o.rd_addr = addr_ff[SLOT_W-1:0];
               rd_vld_in         = 1'b1;
               rd_idx_in         = addr_ff[SLOT_W-1:0];
               addr_in           = addr_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (entry_valid && (rd_data_i.task_key == cmd_ff.task_key) && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_owner_in = rd_data_i.owner_id;
               end
               if (!entry_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (entry_valid && (!best_found_ff ||
                   (rd_data_i.prio_value > best_prio_ff) ||
                   ((rd_data_i.prio_value == best_prio_ff) &&
                    (rd_data_i.task_key > best_key_ff)))) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_prio_in  = rd_data_i.prio_value;
                  best_key_in   = rd_data_i.task_key;
                  best_owner_in = rd_data_i.owner_id;
               end
               if (rd_idx_ff == LAST_SLOT) begin
                  state_in = ENG_WRITE;
               end
            end
         end
         ENG_WRITE: begin
            result_in.status       = ST_OK;
            result_in.popped_owner = '0;
            case (cmd_ff.op)
               OP_ADD: begin
                  mem_req_o.wr_data = '{owner_id:   cmd_ff.owner_id,
                                        task_key:   cmd_ff.task_key,
                                        prio_value: cmd_ff.prio_value};
                  if (hit_found_ff) begin
                     mem_req_o.wr_en   = 1'b1;
                     mem_req_o.wr_addr = hit_idx_ff;
                  end else if (free_found_ff) begin
                     mem_req_o.wr_en       = 1'b1;
                     mem_req_o.wr_addr     = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     result_in.status = ST_FULL;
                  end
               end
               OP_EDIT: begin
                  mem_req_o.wr_data = '{owner_id:   hit_owner_ff,
                                        task_key:   cmd_ff.task_key,
                                        prio_value: cmd_ff.prio_value};
                  if (hit_found_ff) begin
                     mem_req_o.wr_en   = 1'b1;
                     mem_req_o.wr_addr = hit_idx_ff;
                  end else begin
                     result_in.status = ST_NOT_FOUND;
                  end
               end
               OP_REMOVE: begin
                  if (hit_found_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end else begin
                     result_in.status = ST_NOT_FOUND;
                  end
               end
               OP_POP: begin
                  if (best_found_ff) begin
                     valid_in[best_idx_ff]  = 1'b0;
                     result_in.popped_owner = best_owner_ff;
                  end else begin
                     result_in.status = ST_EMPTY;
                  end
               end
               default: begin
                  result_in.status = ST_OK;
               end
            endcase
            state_in = ENG_DONE;
         end
         ENG_DONE: begin
            done_o = out_free_i;
            if (out_free_i) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   assign idle_o   = (state_ff == ENG_IDLE);
   assign result_o = result_ff;

   `KPQ_ASSERT_NOW(a_no_read_outside_scan, state_ff != ENG_SCAN, !rd_vld_ff, "read beat outside scan")
   `KPQ_ASSERT_NOW(a_hit_is_valid, (state_ff == ENG_WRITE) && hit_found_ff, valid_ff[hit_idx_ff], "key hit on empty slot")
   `KPQ_ASSERT_NOW(a_full_only_when_full, (state_ff == ENG_WRITE) && (cmd_ff.op == OP_ADD) && !hit_found_ff && !free_found_ff, &valid_ff, "full reported with free slot")
   `KPQ_ASSERT_NEXT(a_pop_drops_one, (state_ff == ENG_WRITE) && (cmd_ff.op == OP_POP) && best_found_ff, $countones(valid_ff) == $past($countones(valid_ff)) - 1, "pop did not drop one slot")

endmodule

`default_nettype wire

// File: sv/keyed_priority_task_queue_unit.sv
// Top level of the keyed priority task queue: stream ports, slot RAM and scan engine.
//
//   port group  dir  tdata fields (low bit up)                    beats
//   req_        in   op[1:0] owner_id[17:2] task_key[33:18]       one per operation
//                    prio_value[65:34], zero fill to 72 bits
//   rsp_        out  status[1:0] popped_owner[17:2], zero fill    one per operation
//
// An operation runs from acceptance to the next acceptance through these steps: a
// read of every slot of the slot RAM, the last compare, a write-back, a hand-off
// into the output register, which waits while the output is held, and an idle state
// that takes the next beat. The single RAM read port sets the pace of the reads.
// Reset clears the valid marks at once; no clearing pass runs.
// A held result waits in the output register; a second finished result waits in
// the engine, which then accepts no new beat.
`default_nettype none

module keyed_priority_task_queue_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // op, owner_id, task_key, prio_value, zero fill
   input  wire logic [kpq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // status, popped_owner, zero fill
   output logic      [kpq_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import kpq_pkg::*;

   localparam int SLOT_BITS = $bits(slot_type);

   cmd_type              cmd;
   mem_req_type          mem_req;
   logic [SLOT_BITS-1:0] ram_rd_data;
   logic                 eng_idle;
   logic                 eng_done;
   result_type           eng_result;
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;

   assign cmd.op         = op_type'(req_tdata[1:0]);
   assign cmd.owner_id   = req_tdata[17:2];
   assign cmd.task_key   = req_tdata[33:18];
   assign cmd.prio_value = req_tdata[65:34];

   assign req_tready = eng_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   kpq_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (SLOT_W),
      .DATA_W (SLOT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   kpq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start_i    (req_tvalid && req_tready),
      .cmd_i      (cmd),
      .out_free_i (out_free),
      .rd_data_i  (slot_type'(ram_rd_data)),
      .mem_req_o  (mem_req),
      .idle_o     (eng_idle),
      .done_o     (eng_done),
      .result_o   (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(result_type)){1'b0}},
                        rsp_data_ff.popped_owner, rsp_data_ff.status};

endmodule

`default_nettype wire
